// File: rtl/slp_pkg.sv
package slp_pkg;

  localparam int unsigned POS_W       = 7;
  localparam int unsigned MAX_LINE    = 80;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [POS_W-1:0] ADDR_FIRST    = POS_W'(4);
  localparam logic [POS_W-1:0] ADDR_LAST     = POS_W'(11);
  localparam logic [POS_W-1:0] PAYLOAD_FIRST = POS_W'(12);

  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [3:0] REC_DATA32 = 4'd3;
  localparam logic [3:0] REC_START  = 4'd7;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_WORD  = 2'd1,
    KIND_START = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] character;
    logic       line_end;
  } chr_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [15:0] data;
  } rec_t;

  // front to back: address = base + offset, added in the back end
  typedef struct packed {
    kind_t            kind;
    logic [31:0]      base;
    logic [POS_W-1:0] offset;
    logic [15:0]      data;
  } cmd_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'd48 && c <= 8'd57) begin
      v = 4'(c - 8'd48);
    end else if (c >= 8'd65 && c <= 8'd70) begin
      v = 4'(c - 8'd55);
    end
    return v;
  endfunction

endpackage

// File: rtl/slp_front.sv
module slp_front #(
  parameter int unsigned MAX_LINE_CHARS = slp_pkg::MAX_LINE
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  slp_pkg::chr_t chr,
  input  logic [31:0]   code_base,
  output logic          cmd_valid,
  output slp_pkg::cmd_t cmd
);

  localparam int unsigned PW = slp_pkg::POS_W;
  localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_LINE_CHARS);

  logic [PW-1:0] char_position, char_position_next;
  logic          line_good, line_good_next;
  logic [3:0]    record_type, record_type_next;
  logic [31:0]   load_address, load_address_next;
  logic          to_code, to_code_next;
  logic [3:0]    half_byte, half_byte_next;
  logic [PW-1:0] byte_index, byte_index_next;
  logic [15:0]   held_bytes, held_bytes_next;

  logic [3:0]    nib;
  logic [PW-1:0] k;
  logic [31:0]   code_off;

  assign nib      = slp_pkg::hex_value(chr.character);
  assign k        = byte_index - PW'(1);
  assign code_off = load_address - code_base;

  always_comb begin
    char_position_next = char_position;
    line_good_next     = line_good;
    record_type_next   = record_type;
    load_address_next  = load_address;
    to_code_next       = to_code;
    half_byte_next     = half_byte;
    byte_index_next    = byte_index;
    held_bytes_next    = held_bytes;
    cmd_valid          = 1'b0;
    cmd.kind           = slp_pkg::KIND_BYTE;
    cmd.base           = load_address;
    cmd.offset         = k;
    cmd.data           = {8'd0, held_bytes[7:0]};

    if (char_position < POS_LIMIT) begin
      char_position_next = char_position + PW'(1);
      if (char_position == '0) begin
        line_good_next = (chr.character == slp_pkg::CHAR_S);
      end else if (line_good) begin
        if (char_position == PW'(1)) begin
          record_type_next = nib;
        end else if (char_position >= slp_pkg::ADDR_FIRST &&
                     char_position <= slp_pkg::ADDR_LAST) begin
          load_address_next = {load_address[27:0], nib};
          if (char_position == slp_pkg::ADDR_LAST) begin
            to_code_next = (load_address_next >= code_base);
          end
        end else if (char_position >= slp_pkg::PAYLOAD_FIRST &&
                     record_type == slp_pkg::REC_DATA32) begin
          if (!char_position[0]) begin
            half_byte_next = nib;
          end else begin
            if (byte_index != '0) begin
              if (!to_code) begin
                cmd_valid = 1'b1;
              end else if (!k[0]) begin
                held_bytes_next[15:8] = held_bytes[7:0];
              end else begin
                cmd_valid  = 1'b1;
                cmd.kind   = slp_pkg::KIND_WORD;
                cmd.base   = {1'b0, code_off[31:1]};
                cmd.offset = k >> 1;
                cmd.data   = {held_bytes[7:0], held_bytes[15:8]};
              end
            end
            held_bytes_next[7:0] = {half_byte, nib};
            byte_index_next      = byte_index + PW'(1);
          end
        end
      end
    end

    if (chr.line_end) begin
      if (line_good_next && record_type_next == slp_pkg::REC_START) begin
        cmd_valid  = 1'b1;
        cmd.kind   = slp_pkg::KIND_START;
        cmd.base   = '0;
        cmd.offset = '0;
        cmd.data   = '0;
      end
      char_position_next = '0;
      line_good_next     = 1'b0;
      record_type_next   = '0;
      load_address_next  = '0;
      to_code_next       = 1'b0;
      half_byte_next     = '0;
      byte_index_next    = '0;
      held_bytes_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      line_good     <= 1'b0;
      record_type   <= '0;
      load_address  <= '0;
      to_code       <= 1'b0;
      half_byte     <= '0;
      byte_index    <= '0;
      held_bytes    <= '0;
    end else if (accept) begin
      char_position <= char_position_next;
      line_good     <= line_good_next;
      record_type   <= record_type_next;
      load_address  <= load_address_next;
      to_code       <= to_code_next;
      half_byte     <= half_byte_next;
      byte_index    <= byte_index_next;
      held_bytes    <= held_bytes_next;
    end
  end

endmodule

// File: rtl/slp_queue.sv
module slp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  slp_pkg::cmd_t wr_cmd,
  input  logic          rd_en,
  output logic          rd_valid,
  output slp_pkg::cmd_t rd_cmd,
  output logic          q_full
);

  localparam int unsigned DEPTH = slp_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  slp_pkg::cmd_t      slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign rd_valid = (count != '0);
  assign q_full   = (count == CNT_W'(DEPTH));
  assign rd_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/slp_back.sv
module slp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  slp_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          empty,
  input  logic          pop,
  output slp_pkg::rec_t rec
);

  logic          out_valid;
  slp_pkg::rec_t out_rec;

  assign cmd_take = cmd_valid && (!out_valid || pop);
  assign empty    = !out_valid;
  assign rec      = out_rec;

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      out_rec.kind    <= cmd.kind;
      out_rec.address <= cmd.base + 32'(cmd.offset);
      out_rec.data    <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/srecord_loader_parser.sv
// channel  | handshake          | beat
// ---------+--------------------+-------------------------------------
// chr      | push / full        | character, line_end
// rec      | pop / empty        | kind, address, data
// cfg      | cfg_valid/cfg_ready| code_base (32 bits)
//
// One character per cycle while full is low; a result is registered twice on its
// way to rec: front parse into the queue, then offset add in the output register.
// full follows the two-entry command queue between front and back only.
// Synchronous reset clears line state and code_base; cfg_ready is always high.
module srecord_loader_parser #(
  parameter int unsigned MAX_LINE_CHARS = slp_pkg::MAX_LINE
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  slp_pkg::chr_t chr,
  output logic          empty,
  input  logic          pop,
  output slp_pkg::rec_t rec,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data
);

  logic          accept;
  logic [31:0]   code_base;
  logic          front_valid;
  slp_pkg::cmd_t front_cmd;
  logic          q_valid;
  slp_pkg::cmd_t q_cmd;
  logic          q_take;
  logic          q_full;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      code_base <= cfg_data;
    end
  end

  slp_front #(
    .MAX_LINE_CHARS(MAX_LINE_CHARS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .chr       (chr),
    .code_base (code_base),
    .cmd_valid (front_valid),
    .cmd       (front_cmd)
  );

  slp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept && front_valid),
    .wr_cmd   (front_cmd),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd),
    .q_full   (q_full)
  );

  slp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_take  (q_take),
    .empty     (empty),
    .pop       (pop),
    .rec       (rec)
  );

endmodule

// File: test/srecord_loader_parser_tb.sv
module srecord_loader_parser_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          push = 1'b0;
  logic          full;
  slp_pkg::chr_t chr = '0;
  logic          empty;
  logic          pop = 1'b0;
  slp_pkg::rec_t rec;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [31:0]   cfg_data = '0;

  srecord_loader_parser dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .chr       (chr),
    .empty     (empty),
    .pop       (pop),
    .rec       (rec),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  slp_pkg::chr_t char_q[$];
  slp_pkg::chr_t line_buf[$];
  slp_pkg::rec_t expected_recs[$];

  int idle_pct = 25;
  int noise_pct = 0;
  int errors = 0;
  int cycles = 0;
  int chars_sent = 0;
  int lines_sent = 0;
  int bases_used = 0;
  int recs_checked = 0;
  int kind_seen[3] = '{0, 0, 0};

  // parser state mirror
  logic [31:0] code_base = '0;
  logic [6:0]  line_pos = '0;
  logic        line_ok = 1'b0;
  logic [3:0]  rec_type = '0;
  logic [31:0] load_addr = '0;
  logic        to_code = 1'b0;
  logic [3:0]  hi_digit = '0;
  logic [6:0]  pairs = '0;
  logic [15:0] held = '0;

  function automatic logic [3:0] digit_of(logic [7:0] ch);
    if (ch >= "0" && ch <= "9") begin
      return ch[3:0];
    end
    if (ch >= "A" && ch <= "F") begin
      return ch[3:0] + 4'd9;
    end
    return 4'd0;
  endfunction

  task automatic expect_rec(slp_pkg::kind_t k, logic [31:0] a, logic [15:0] d);
    slp_pkg::rec_t r;
    r.kind = k;
    r.address = a;
    r.data = d;
    expected_recs.push_back(r);
  endtask

  task automatic parse_char(slp_pkg::chr_t c);
    logic [6:0]  p;
    logic [3:0]  nib;
    logic [7:0]  prev;
    logic [6:0]  k;
    logic [31:0] idx;
    p = line_pos;
    if (p < slp_pkg::MAX_LINE) begin
      nib = digit_of(c.character);
      line_pos = p + 7'd1;
      if (p == 0) begin
        line_ok = (c.character == slp_pkg::CHAR_S);
      end else if (line_ok) begin
        if (p == 1) begin
          rec_type = nib;
        end else if (p >= slp_pkg::ADDR_FIRST && p <= slp_pkg::ADDR_LAST) begin
          load_addr = {load_addr[27:0], nib};
          if (p == slp_pkg::ADDR_LAST) begin
            to_code = (load_addr >= code_base);
          end
        end else if (p >= slp_pkg::PAYLOAD_FIRST && rec_type == slp_pkg::REC_DATA32) begin
          if (!p[0]) begin
            hi_digit = nib;
          end else begin
            // the pair just finished proves the previous one was payload
            if (pairs != 0) begin
              prev = held[7:0];
              k = pairs - 7'd1;
              if (!to_code) begin
                expect_rec(slp_pkg::KIND_BYTE, load_addr + 32'(k), {8'h00, prev});
              end else if (!k[0]) begin
                held[15:8] = prev;
              end else begin
                idx = ((load_addr - code_base) >> 1) + 32'(k >> 1);
                expect_rec(slp_pkg::KIND_WORD, idx, {prev, held[15:8]});
              end
            end
            held[7:0] = {hi_digit, nib};
            pairs = pairs + 7'd1;
          end
        end
      end
    end
    if (c.line_end) begin
      if (line_ok && rec_type == slp_pkg::REC_START) begin
        expect_rec(slp_pkg::KIND_START, '0, '0);
      end
      line_pos = '0;
      line_ok = 1'b0;
      rec_type = '0;
      load_addr = '0;
      to_code = 1'b0;
      hi_digit = '0;
      pairs = '0;
      held = '0;
    end
  endtask

  task automatic flag_mismatch(string msg);
    $display("[%0d] mismatch: %s", cycles, msg);
    errors++;
  endtask

  task automatic check_rec(slp_pkg::rec_t got);
    slp_pkg::rec_t want;
    if (expected_recs.size() == 0) begin
      flag_mismatch($sformatf("unexpected beat kind=%0d address=%h data=%h",
                              got.kind, got.address, got.data));
    end else begin
      want = expected_recs.pop_front();
      if (got.kind !== want.kind) begin
        flag_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      end
      if (got.address !== want.address) begin
        flag_mismatch($sformatf("address %h, expected %h", got.address, want.address));
      end
      if (got.data !== want.data) begin
        flag_mismatch($sformatf("data %h, expected %h", got.data, want.data));
      end
      recs_checked++;
      kind_seen[want.kind]++;
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        parse_char(chr);
      end
      if (!push || !full) begin
        if (char_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          chr  <= char_q.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        check_rec(rec);
      end
      pop <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_char(logic [7:0] c);
    slp_pkg::chr_t t;
    t.character = c;
    t.line_end = 1'b0;
    line_buf.push_back(t);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i]);
    end
  endtask

  task automatic push_hex(logic [31:0] v, int digits);
    logic [3:0] nib;
    logic [7:0] ch;
    for (int i = digits - 1; i >= 0; i--) begin
      nib = v[4*i +: 4];
      ch = (nib < 10) ? 8'("0") + 8'(nib) : 8'("A") + 8'(nib) - 8'd10;
      if (nib >= 10 && $urandom_range(99) < 4) begin
        ch = ch + 8'd32;
      end
      if ($urandom_range(99) < noise_pct) begin
        ch = 8'($urandom_range(255));
      end
      push_char(ch);
    end
  endtask

  task automatic commit_line(bit ends, int cut);
    slp_pkg::chr_t t;
    while (cut > 0 && line_buf.size() > cut) begin
      t = line_buf.pop_back();
    end
    if (ends && line_buf.size() != 0) begin
      t = line_buf.pop_back();
      t.line_end = 1'b1;
      line_buf.push_back(t);
      lines_sent++;
    end
    foreach (line_buf[i]) begin
      char_q.push_back(line_buf[i]);
    end
    chars_sent += line_buf.size();
    line_buf.delete();
  endtask

  task automatic settle();
    while (char_q.size() != 0 || push || expected_recs.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_base(logic [31:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    code_base = v;
    cfg_valid <= 1'b0;
    bases_used++;
  endtask

  function automatic logic [31:0] near_base();
    case ($urandom_range(3))
      0: return code_base + 32'($urandom_range(200));
      1: return code_base - 32'($urandom_range(1, 200));
      2: return 32'hFFFF_FFF0 + 32'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  task automatic random_line();
    int sel;
    int nb;
    int n;
    sel = $urandom_range(99);
    noise_pct = ($urandom_range(9) == 0) ? 8 : 0;
    if (sel < 62) begin
      nb = ($urandom_range(19) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 12);
      push_text("S3");
      push_hex(32'(nb + 5), 2);
      push_hex(near_base(), 8);
      repeat (nb + 1) push_hex($urandom, 2);
    end else if (sel < 72) begin
      push_text("S705");
      push_hex($urandom, 8);
      push_hex($urandom, 2);
    end else if (sel < 84) begin
      push_char("S");
      push_hex(32'($urandom_range(15)), 1);
      push_hex($urandom, 2);
      push_hex($urandom, 8);
      repeat ($urandom_range(0, 8)) push_hex($urandom, 2);
    end else begin
      n = $urandom_range(1, 24);
      if ($urandom_range(1) == 0) begin
        push_char("S");
      end
      repeat (n) push_char(8'($urandom_range(255)));
    end
    noise_pct = 0;
    commit_line(1'b1, ($urandom_range(19) == 0) ? $urandom_range(1, 14) : 0);
  endtask

  initial begin
    logic [31:0] phase_base[5];
    int target;
    phase_base = '{32'h0000_4000, 32'h0000_0000, 32'hFFFF_FFFF, $urandom, 32'h8000_0000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // code base still at reset value: every S3 address goes to code memory
    push_text("S30900000010FF00A57E");   commit_line(1'b1, 0);
    push_text("S70500000000FA");         commit_line(1'b1, 0);
    push_text("S");                      commit_line(1'b1, 0);
    push_text("X3070000000011223344");   commit_line(1'b1, 0);
    push_text("S1051234AABBCC");         commit_line(1'b1, 0);
    push_text("S305000000207E");         commit_line(1'b1, 0);
    push_text("S305000000");             commit_line(1'b1, 0);
    settle();

    set_base(32'hFFFF_FFFF);
    push_text("S309FFFFFFFE010203047E"); commit_line(1'b1, 0);
    push_text("S30700000040g9Az@F55");   commit_line(1'b1, 0);
    push_text("S30700000050ABCDE");      commit_line(1'b1, 0);
    push_text("S309FFFFFFFF1122334455"); commit_line(1'b1, 0);
    push_char(8'h00);
    push_char(8'hFF);
    commit_line(1'b1, 0);
    push_text("S32D00000100");
    repeat (41) push_hex($urandom, 2);
    commit_line(1'b1, 0);
    // base changes between the address and the payload of a code line
    push_text("S309FFFFFFFFAABB");       commit_line(1'b0, 0);
    settle();
    set_base(32'h0000_0000);
    push_text("CCDDEE");                 commit_line(1'b1, 0);
    settle();

    foreach (phase_base[ph]) begin
      idle_pct = (ph == 2) ? 0 : 25;
      set_base(phase_base[ph]);
      target = chars_sent + 220;
      while (chars_sent < target) begin
        random_line();
      end
      settle();
    end

    $display("Sent %0d characters in %0d lines over %0d code base settings",
             chars_sent, lines_sent, bases_used);
    $display("Checked %0d beats: %0d byte writes, %0d word writes, %0d starts",
             recs_checked, kind_seen[slp_pkg::KIND_BYTE], kind_seen[slp_pkg::KIND_WORD],
             kind_seen[slp_pkg::KIND_START]);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
